### design/spdm_pkg.sv
`default_nettype none
package spdm_pkg;

  localparam int unsigned POOL_SIZE_DEF  = 80;
  localparam int unsigned DRAW_COUNT_DEF = 20;
  localparam int unsigned MAX_ROUNDS_DEF = 400;

  // class code width, enough for the largest pool and for the low-seven-bits sampler
  localparam int unsigned CLS_W = 7;

  localparam logic [63:0] SM_GOLD   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL1   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL2   = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] PCG32_MUL = 64'd6364136223846793005;
  localparam logic [63:0] PCG64_MHI = 64'h2360_ED05_1FC6_5DA4;
  localparam logic [63:0] PCG64_MLO = 64'h4385_DF64_9FCC_F645;

  localparam logic [2:0] GEN_SM   = 3'd0;
  localparam logic [2:0] GEN_X256 = 3'd1;
  localparam logic [2:0] GEN_X128 = 3'd2;
  localparam logic [2:0] GEN_P32  = 3'd3;
  localparam logic [2:0] GEN_P64  = 3'd4;

  localparam logic [2:0] SMP_TRUNC = 3'd0;
  localparam logic [2:0] SMP_MOD   = 3'd1;
  localparam logic [2:0] SMP_UMOD  = 3'd2;
  localparam logic [2:0] SMP_LEM   = 3'd3;
  localparam logic [2:0] SMP_D53   = 3'd4;

  typedef struct packed {
    logic [31:0] seed;
    logic [2:0]  generator;
    logic [2:0]  sampler;
  } in_item_t;

  typedef struct packed {
    logic [63:0] mask_low;
    logic [15:0] mask_high;
    logic        complete;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_SM_ADD, ST_SM1, ST_SM1_W, ST_SM2, ST_SM2_W, ST_SEED_ST,
    ST_PCG, ST_PCG_W, ST_ROUND, ST_WORD, ST_SAMPLE, ST_MOD, ST_D53, ST_MARK,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_SM_ADD, OP_MUL_START, OP_MUL_WB, OP_SEED_STORE,
    OP_ROUND_INC, OP_WORD, OP_SAMPLE, OP_MOD_STEP, OP_D53_CLASS, OP_MARK, OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    MS_SM1, MS_SM2, MS_PCG32, MS_PCG64
  } msel_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
  } cmd_t;

  typedef struct packed {
    logic       mul_done;
    logic       mod_last;
    logic       seed_last;
    logic       taken_done;
    logic       rounds_full;
    logic       out_full;
    logic [2:0] gen;
    logic [2:0] smp;
  } status_t;

endpackage
`default_nettype wire

### design/seeded_prng_draw_mask_unit.sv
`default_nettype none
// Flow: accept plus a setup state, then seeding (xoshiro: four splitmix chains, pcg: one
// product), then per round a word fetch and a sample; double53 adds a second word fetch and
// a class step, the modulo samplers a quotient and a remainder step; at most MAX_ROUNDS
// rounds, then out. Throughput: one item at a time. Products share one 32x32 multiplier.
// Reset (rst_n, synchronous) returns the controller to idle and empties the output register.
module seeded_prng_draw_mask_unit #(
  parameter int unsigned POOL_SIZE  = spdm_pkg::POOL_SIZE_DEF,
  parameter int unsigned DRAW_COUNT = spdm_pkg::DRAW_COUNT_DEF,
  parameter int unsigned MAX_ROUNDS = spdm_pkg::MAX_ROUNDS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire spdm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spdm_pkg::out_item_t      out_item
);
  import spdm_pkg::*;

  cmd_t    cmd;
  status_t status;

  spdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  spdm_dp #(
    .POOL_SIZE  (POOL_SIZE),
    .DRAW_COUNT (DRAW_COUNT),
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire

### design/spdm_mul.sv
`default_nettype none
module spdm_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] a,
  input  wire logic [127:0] b,
  input  wire logic [127:0] c,
  output logic              done,
  output logic [127:0]      p
);
  // a*b+c mod 2^128, one 32x32 partial product per cycle
  logic [127:0] a_r, b_r, acc_r;
  logic [1:0]   i_r, j_r;
  logic         busy_r, done_r;
  logic [63:0]  prod;
  logic [1:0]   ij;

  assign prod = a_r[32*i_r +: 32] * b_r[32*j_r +: 32];
  assign ij   = i_r + j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= 2'd0;
        j_r    <= 2'd0;
      end else if (busy_r) begin
        if (j_r == ~i_r) begin
          if (i_r == 2'd3) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            i_r <= i_r + 2'd1;
            j_r <= 2'd0;
          end
        end else begin
          j_r <= j_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= c;
    end else if (busy_r) begin
      acc_r <= acc_r + (128'(prod) << {ij, 5'd0});
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule
`default_nettype wire

### design/spdm_dp.sv
`default_nettype none
module spdm_dp #(
  parameter int unsigned POOL_SIZE  = spdm_pkg::POOL_SIZE_DEF,
  parameter int unsigned DRAW_COUNT = spdm_pkg::DRAW_COUNT_DEF,
  parameter int unsigned MAX_ROUNDS = spdm_pkg::MAX_ROUNDS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire spdm_pkg::cmd_t      cmd,
  output spdm_pkg::status_t        status,
  input  wire spdm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spdm_pkg::out_item_t      out_item
);
  import spdm_pkg::*;

  localparam int unsigned IDX_W = $clog2(POOL_SIZE);
  localparam int unsigned TK_W  = $clog2(DRAW_COUNT + 1);
  localparam int unsigned RD_W  = $clog2(MAX_ROUNDS + 1);
  localparam logic [7:0]  POOL_W = 8'(POOL_SIZE);
  localparam logic [32:0] THR   = 33'((64'd1 << 32) % POOL_SIZE);
  localparam logic [32:0] ULIM  = 33'(64'd1 << 32) - THR;
  // ceil(2^(32+l)/pool), l = ceil(log2(pool)): exact quotient for every 32-bit word
  localparam int unsigned RCP_SH = 32 + IDX_W;
  localparam logic [33:0] RCP =
    34'(((64'd1 << RCP_SH) + 64'(POOL_SIZE) - 64'd1) / 64'(POOL_SIZE));

  logic [2:0]            gen_r, smp_r;
  logic [63:0]           t_r, z_r;
  logic [63:0]           st_r [4];
  logic [127:0]          inc_r;
  logic [1:0]            scnt_r;
  logic [31:0]           w_r, w1_r, quo_r;
  logic                  mcnt_r;
  logic [CLS_W-1:0]      c_r;
  logic                  cv_r;
  logic [60:0]           p_r;
  logic [POOL_SIZE-1:0]  mask_r;
  logic [TK_W-1:0]       taken_r;
  logic [RD_W-1:0]       rounds_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic         mul_start, mul_done;
  logic [127:0] mul_a, mul_b, mul_c, mul_p;

  spdm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .c     (mul_c),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign mul_start = (cmd.op == OP_MUL_START);

  always_comb begin
    mul_a = {64'd0, z_r};
    mul_b = {64'd0, SM_MUL1};
    mul_c = '0;
    unique case (cmd.msel)
      MS_SM1: begin
      end
      MS_SM2: mul_b = {64'd0, SM_MUL2};
      MS_PCG32: begin
        mul_a = {64'd0, st_r[0]};
        mul_b = {64'd0, PCG32_MUL};
        mul_c = inc_r;
      end
      MS_PCG64: begin
        mul_a = {st_r[1], st_r[0]};
        mul_b = {PCG64_MHI, PCG64_MLO};
        mul_c = inc_r;
      end
      default: begin
      end
    endcase
  end

  // next word of the selected generator, plus the xoshiro state update
  logic [31:0] word;
  logic [63:0] st_nxt [4];
  always_comb begin
    logic [63:0] sum, r64, t64, n0, n1, n2, n3, x64;
    logic [31:0] m5, rl, t32, a0, a1, a2, a3, xs;
    logic [4:0]  rot32;
    logic [5:0]  rot64;
    logic [127:0] dbl;
    logic [63:0]  dbl32;
    word = 32'd0;
    for (int k = 0; k < 4; k++) st_nxt[k] = st_r[k];
    sum = st_r[0] + st_r[3];
    r64 = {sum[40:0], sum[63:41]} + st_r[0];
    t64 = st_r[1] << 17;
    n2  = st_r[2] ^ st_r[0];
    n3  = st_r[3] ^ st_r[1];
    n1  = st_r[1] ^ n2;
    n0  = st_r[0] ^ n3;
    m5  = st_r[1][31:0] + (st_r[1][31:0] << 2);
    rl  = {m5[24:0], m5[31:25]};
    t32 = st_r[1][31:0] << 9;
    a2  = st_r[2][31:0] ^ st_r[0][31:0];
    a3  = st_r[3][31:0] ^ st_r[1][31:0];
    a1  = st_r[1][31:0] ^ a2;
    a0  = st_r[0][31:0] ^ a3;
    xs  = 32'(((st_r[0] >> 18) ^ st_r[0]) >> 27);
    rot32 = st_r[0][63:59];
    dbl32 = {xs, xs} >> rot32;
    x64 = st_r[1] ^ st_r[0];
    rot64 = st_r[1][63:58];
    dbl = {x64, x64} >> rot64;
    unique case (gen_r)
      GEN_SM:   word = z_r[63:32];
      GEN_X256: begin
        word = r64[63:32];
        st_nxt[0] = n0;
        st_nxt[1] = n1;
        st_nxt[2] = n2 ^ t64;
        st_nxt[3] = {n3[18:0], n3[63:19]};
      end
      GEN_X128: begin
        word = rl + (rl << 3);
        st_nxt[0] = {32'd0, a0};
        st_nxt[1] = {32'd0, a1};
        st_nxt[2] = {32'd0, a2 ^ t32};
        st_nxt[3] = {32'd0, a3[20:0], a3[31:21]};
      end
      GEN_P32:  word = dbl32[31:0];
      GEN_P64:  word = dbl[63:32];
      default:  word = 32'd0;
    endcase
  end

  // double53: round the product to 53 significant bits, then take the integer part
  logic [CLS_W-1:0] d53_cls;
  always_comb begin
    logic [2:0]  s;
    logic [60:0] q, remv, half, pr;
    logic [7:0]  c8;
    s = 3'd0;
    for (int k = 0; k < 7; k++) begin
      if (p_r[53+k]) s = 3'(k + 1);
    end
    q    = p_r >> s;
    remv = p_r & ((61'd1 << s) - 61'd1);
    half = (s != 3'd0) ? (61'd1 << (s - 3'd1)) : 61'd0;
    if (s != 3'd0 && (remv > half || (remv == half && q[0]))) q = q + 61'd1;
    pr = q << s;
    c8 = pr[60:53];
    if (c8 >= POOL_W) c8 = POOL_W - 8'd1;
    d53_cls = c8[CLS_W-1:0];
  end

  logic [39:0]      prod40;
  logic [52:0]      n53;
  logic [65:0]      quo_full;
  logic [31:0]      rem32;
  logic [63:0]      inc_lo;
  logic [127:0]     mask_full;
  logic             ok;

  assign prod40 = 40'(w_r) * 40'(POOL_W);
  assign n53    = {w1_r[31:5], w_r[31:6]};
  assign quo_full = 66'(w_r) * 66'(RCP);
  assign rem32  = w_r - 32'(quo_r * 32'(POOL_SIZE));
  assign inc_lo = {31'd0, in_item.seed, 1'b1};
  assign mask_full = 128'(mask_r);
  assign ok = (taken_r == TK_W'(DRAW_COUNT));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        gen_r    <= in_item.generator;
        smp_r    <= in_item.sampler;
        t_r      <= 64'(in_item.seed);
        st_r[0]  <= inc_lo + 64'(in_item.seed);
        st_r[1]  <= 64'd0;
        inc_r    <= {64'd0, inc_lo};
        scnt_r   <= 2'd0;
        mask_r   <= '0;
        taken_r  <= '0;
        rounds_r <= '0;
      end
      OP_SM_ADD: begin
        t_r <= t_r + SM_GOLD;
        z_r <= (t_r + SM_GOLD) ^ ((t_r + SM_GOLD) >> 30);
      end
      OP_MUL_WB: begin
        unique case (cmd.msel)
          MS_SM1:   z_r <= mul_p[63:0] ^ (mul_p[63:0] >> 27);
          MS_SM2:   z_r <= mul_p[63:0] ^ (mul_p[63:0] >> 31);
          MS_PCG32: st_r[0] <= mul_p[63:0];
          MS_PCG64: begin
            st_r[0] <= mul_p[63:0];
            st_r[1] <= mul_p[127:64];
          end
          default: begin
          end
        endcase
      end
      OP_SEED_STORE: begin
        st_r[scnt_r] <= (gen_r == GEN_X128) ? {32'd0, z_r[63:32]} : z_r;
        scnt_r <= scnt_r + 2'd1;
      end
      OP_ROUND_INC: rounds_r <= rounds_r + RD_W'(1);
      OP_WORD: begin
        w1_r <= w_r;
        w_r  <= word;
        for (int k = 0; k < 4; k++) st_r[k] <= st_nxt[k];
      end
      OP_SAMPLE: begin
        mcnt_r <= 1'b0;
        p_r    <= 61'(n53) * 61'(POOL_W);
        priority case (smp_r)
          SMP_TRUNC: begin
            c_r  <= prod40[32 +: CLS_W];
            cv_r <= 1'b1;
          end
          SMP_MOD:  cv_r <= 1'b1;
          SMP_UMOD: cv_r <= ({1'b0, w_r} < ULIM);
          SMP_LEM: begin
            c_r  <= prod40[32 +: CLS_W];
            cv_r <= ({1'b0, prod40[31:0]} >= THR);
          end
          SMP_D53:  cv_r <= 1'b1;
          default: begin
            c_r  <= w_r[CLS_W-1:0];
            cv_r <= (8'(w_r[CLS_W-1:0]) < POOL_W);
          end
        endcase
      end
      // first step: quotient by reciprocal, second step: remainder
      OP_MOD_STEP: begin
        if (!mcnt_r) quo_r <= 32'(quo_full >> RCP_SH);
        else c_r <= CLS_W'(rem32);
        mcnt_r <= 1'b1;
      end
      OP_D53_CLASS: c_r <= d53_cls;
      OP_MARK: begin
        if (cv_r && !mask_r[c_r[IDX_W-1:0]]) begin
          mask_r[c_r[IDX_W-1:0]] <= 1'b1;
          taken_r <= taken_r + TK_W'(1);
        end
      end
      OP_OUT: begin
        out_r.mask_low  <= ok ? mask_full[63:0] : 64'd0;
        out_r.mask_high <= ok ? mask_full[79:64] : 16'd0;
        out_r.complete  <= ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    status.mul_done    = mul_done;
    status.mod_last    = mcnt_r;
    status.seed_last   = (scnt_r == 2'd3);
    status.taken_done  = ok;
    status.rounds_full = (rounds_r == RD_W'(MAX_ROUNDS));
    status.out_full    = out_valid_r && !out_ready;
    status.gen         = gen_r;
    status.smp         = smp_r;
  end
endmodule
`default_nettype wire

### design/spdm_ctrl.sv
`default_nettype none
module spdm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spdm_pkg::status_t status,
  output spdm_pkg::cmd_t         cmd
);
  import spdm_pkg::*;

  state_t state_r, state_nxt;
  logic   seeding_r, seeding_nxt;
  logic   second_r, second_nxt;
  state_t fetch_st;
  logic   pcg64;

  assign fetch_st = (status.gen == GEN_SM) ? ST_SM_ADD : ST_WORD;
  assign pcg64    = (status.gen == GEN_P64);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      seeding_r <= 1'b0;
      second_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seeding_r <= seeding_nxt;
      second_r  <= second_nxt;
    end
  end

  always_comb begin
    logic       gen_done;
    state_t     after_word;
    logic       second_next_word;
    gen_done         = 1'b0;
    second_next_word = 1'b0;
    // double53 needs a second word before sampling
    if (status.smp == SMP_D53 && !second_r) begin
      after_word       = fetch_st;
      second_next_word = 1'b1;
    end else begin
      after_word = ST_SAMPLE;
    end
    state_nxt   = state_r;
    seeding_nxt = seeding_r;
    second_nxt  = second_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_START;
      ST_START: begin
        second_nxt = 1'b0;
        priority case (status.gen)
          GEN_X256, GEN_X128: begin
            state_nxt   = ST_SM_ADD;
            seeding_nxt = 1'b1;
          end
          GEN_P32, GEN_P64: begin
            state_nxt   = ST_PCG;
            seeding_nxt = 1'b1;
          end
          default: state_nxt = ST_ROUND;
        endcase
      end
      ST_SM_ADD: state_nxt = ST_SM1;
      ST_SM1:    state_nxt = ST_SM1_W;
      ST_SM1_W:  if (status.mul_done) state_nxt = ST_SM2;
      ST_SM2:    state_nxt = ST_SM2_W;
      ST_SM2_W:  if (status.mul_done) state_nxt = seeding_r ? ST_SEED_ST : ST_WORD;
      ST_SEED_ST: begin
        if (status.seed_last) begin
          state_nxt   = ST_ROUND;
          seeding_nxt = 1'b0;
        end else begin
          state_nxt = ST_SM_ADD;
        end
      end
      ST_PCG: state_nxt = ST_PCG_W;
      ST_PCG_W: begin
        if (status.mul_done) begin
          if (seeding_r) begin
            state_nxt   = ST_ROUND;
            seeding_nxt = 1'b0;
          end else begin
            gen_done = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        if (status.taken_done || status.rounds_full) state_nxt = ST_FINISH;
        else state_nxt = fetch_st;
      end
      ST_WORD: begin
        if (status.gen == GEN_P32 || status.gen == GEN_P64) state_nxt = ST_PCG;
        else gen_done = 1'b1;
      end
      ST_SAMPLE: begin
        priority case (status.smp)
          SMP_MOD, SMP_UMOD: state_nxt = ST_MOD;
          SMP_D53:           state_nxt = ST_D53;
          default:           state_nxt = ST_MARK;
        endcase
      end
      ST_MOD:    if (status.mod_last) state_nxt = ST_MARK;
      ST_D53:    state_nxt = ST_MARK;
      ST_MARK:   state_nxt = ST_ROUND;
      ST_FINISH: if (!status.out_full) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    if (gen_done) begin
      state_nxt  = after_word;
      second_nxt = second_next_word;
    end
  end

  always_comb begin
    cmd.op   = OP_NOP;
    cmd.msel = MS_SM1;
    unique case (state_r)
      ST_IDLE:    if (in_valid) cmd.op = OP_LOAD;
      ST_START:   cmd.op = OP_NOP;
      ST_SM_ADD:  cmd.op = OP_SM_ADD;
      ST_SM1:     cmd.op = OP_MUL_START;
      ST_SM1_W:   if (status.mul_done) cmd.op = OP_MUL_WB;
      ST_SM2: begin
        cmd.op   = OP_MUL_START;
        cmd.msel = MS_SM2;
      end
      ST_SM2_W: begin
        cmd.msel = MS_SM2;
        if (status.mul_done) cmd.op = OP_MUL_WB;
      end
      ST_SEED_ST: cmd.op = OP_SEED_STORE;
      ST_PCG: begin
        cmd.op   = OP_MUL_START;
        cmd.msel = pcg64 ? MS_PCG64 : MS_PCG32;
      end
      ST_PCG_W: begin
        cmd.msel = pcg64 ? MS_PCG64 : MS_PCG32;
        if (status.mul_done) cmd.op = OP_MUL_WB;
      end
      ST_ROUND: if (!status.taken_done && !status.rounds_full) cmd.op = OP_ROUND_INC;
      ST_WORD:   cmd.op = OP_WORD;
      ST_SAMPLE: cmd.op = OP_SAMPLE;
      ST_MOD:    cmd.op = OP_MOD_STEP;
      ST_D53:    cmd.op = OP_D53_CLASS;
      ST_MARK:   cmd.op = OP_MARK;
      ST_FINISH: if (!status.out_full) cmd.op = OP_OUT;
      default:   cmd.op = OP_NOP;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
endmodule
`default_nettype wire

### test/tb_seeded_prng_draw_mask_unit.sv
`default_nettype none
module tb_seeded_prng_draw_mask_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import spdm_pkg::*;

  localparam int unsigned POOL = POOL_SIZE_DEF;
  localparam int unsigned DRAWS = DRAW_COUNT_DEF;
  localparam int unsigned ROUND_CAP = MAX_ROUNDS_DEF;
  localparam int unsigned N_RANDOM = 1306;
  localparam int unsigned IDLE_LIMIT = 200000;

  // codes outside the package
  localparam logic [2:0] GEN_DEAD5 = 3'd5;
  localparam logic [2:0] GEN_DEAD6 = 3'd6;
  localparam logic [2:0] GEN_DEAD7 = 3'd7;
  localparam logic [2:0] SMP_LOW7 = 3'd5;
  localparam logic [2:0] SMP_RSV6 = 3'd6;
  localparam logic [2:0] SMP_RSV7 = 3'd7;

  localparam out_item_t FAILED = '{mask_low: 64'd0, mask_high: 16'd0, complete: 1'b0};

  typedef struct packed {
    logic [31:0] seed;
    logic [2:0]  gen;
    logic [2:0]  smp;
    logic        known;
    out_item_t   res;
  } vec_t;

  // dead generators always give a zero word, so only class 0 is ever drawn
  localparam vec_t DIR_VECS [24] = '{
    '{32'h0000_0000, GEN_SM,    SMP_TRUNC, 1'b0, FAILED},
    '{32'hFFFF_FFFF, GEN_SM,    SMP_MOD,   1'b0, FAILED},
    '{32'h0000_0000, GEN_X256,  SMP_UMOD,  1'b0, FAILED},
    '{32'hFFFF_FFFF, GEN_X256,  SMP_LEM,   1'b0, FAILED},
    '{32'h0000_0000, GEN_X128,  SMP_D53,   1'b0, FAILED},
    '{32'hFFFF_FFFF, GEN_X128,  SMP_LOW7,  1'b0, FAILED},
    '{32'h0000_0000, GEN_P32,   SMP_RSV6,  1'b0, FAILED},
    '{32'hFFFF_FFFF, GEN_P32,   SMP_RSV7,  1'b0, FAILED},
    '{32'h0000_0000, GEN_P64,   SMP_TRUNC, 1'b0, FAILED},
    '{32'hFFFF_FFFF, GEN_P64,   SMP_D53,   1'b0, FAILED},
    '{32'h8000_0000, GEN_SM,    SMP_D53,   1'b0, FAILED},
    '{32'h7FFF_FFFF, GEN_X256,  SMP_D53,   1'b0, FAILED},
    '{32'h0000_0001, GEN_P32,   SMP_D53,   1'b0, FAILED},
    '{32'h5555_5555, GEN_P64,   SMP_LEM,   1'b0, FAILED},
    '{32'hAAAA_AAAA, GEN_X128,  SMP_UMOD,  1'b0, FAILED},
    '{32'h1234_5678, GEN_P64,   SMP_LOW7,  1'b0, FAILED},
    '{32'hDEAD_BEEF, GEN_SM,    SMP_LOW7,  1'b0, FAILED},
    '{32'h0F0F_0F0F, GEN_P32,   SMP_MOD,   1'b0, FAILED},
    '{32'h0000_0000, GEN_DEAD5, SMP_TRUNC, 1'b1, FAILED},
    '{32'hFFFF_FFFF, GEN_DEAD6, SMP_MOD,   1'b1, FAILED},
    '{32'h1357_9BDF, GEN_DEAD7, SMP_LOW7,  1'b1, FAILED},
    '{32'h0000_0000, GEN_DEAD5, SMP_D53,   1'b1, FAILED},
    '{32'hFFFF_FFFF, GEN_DEAD7, SMP_RSV7,  1'b1, FAILED},
    '{32'h2468_ACE0, GEN_DEAD6, SMP_LEM,   1'b1, FAILED}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  logic cur_known = 1'b0;
  out_item_t cur_res = '0;
  out_item_t exp_masks[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;

  // generator state of the predictor
  bit [63:0] sm_st;
  bit [63:0] xo256[4];
  bit [31:0] xo128[4];
  bit [63:0] p32_st, p32_inc;
  bit [127:0] p64_st, p64_inc;

  always #10 clk = ~clk;

  seeded_prng_draw_mask_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  function automatic bit [63:0] rotl64(bit [63:0] x, int unsigned k);
    k = k & 63;
    return (k == 0) ? x : ((x << k) | (x >> (64 - k)));
  endfunction

  function automatic bit [31:0] rotl32(bit [31:0] x, int unsigned k);
    k = k & 31;
    return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
  endfunction

  function automatic bit [63:0] mix64(ref bit [63:0] s);
    bit [63:0] z;
    s = s + SM_GOLD;
    z = s;
    z = (z ^ (z >> 30)) * SM_MUL1;
    z = (z ^ (z >> 27)) * SM_MUL2;
    return z ^ (z >> 31);
  endfunction

  function automatic bit [127:0] pcg64_adv(bit [127:0] s);
    return s * {PCG64_MHI, PCG64_MLO} + p64_inc;
  endfunction

  function automatic void seed_gens(bit [31:0] seed);
    bit [63:0] t;
    bit [63:0] w;
    sm_st = {32'd0, seed};
    t = {32'd0, seed};
    for (int i = 0; i < 4; i++) xo256[i] = mix64(t);
    t = {32'd0, seed};
    for (int i = 0; i < 4; i++) begin
      w = mix64(t);
      xo128[i] = w[63:32];
    end
    p32_inc = ({32'd0, seed} << 1) | 64'd1;
    p32_st = p32_inc + {32'd0, seed};
    p32_st = p32_st * PCG32_MUL + p32_inc;
    p64_inc = {64'd0, p32_inc};
    p64_st = pcg64_adv(p64_inc + {96'd0, seed});
  endfunction

  function automatic bit [31:0] gen_word(bit [2:0] g);
    bit [63:0] r, t, old;
    bit [31:0] r32, t32;
    bit [127:0] o128;
    case (g)
      GEN_SM: begin
        r = mix64(sm_st);
        return r[63:32];
      end
      GEN_X256: begin
        r = rotl64(xo256[0] + xo256[3], 23) + xo256[0];
        t = xo256[1] << 17;
        xo256[2] ^= xo256[0]; xo256[3] ^= xo256[1];
        xo256[1] ^= xo256[2]; xo256[0] ^= xo256[3];
        xo256[2] ^= t; xo256[3] = rotl64(xo256[3], 45);
        return r[63:32];
      end
      GEN_X128: begin
        t32 = xo128[1] * 32'd5;
        r32 = rotl32(t32, 7) * 32'd9;
        t32 = xo128[1] << 9;
        xo128[2] ^= xo128[0]; xo128[3] ^= xo128[1];
        xo128[1] ^= xo128[2]; xo128[0] ^= xo128[3];
        xo128[2] ^= t32; xo128[3] = rotl32(xo128[3], 11);
        return r32;
      end
      GEN_P32: begin
        old = p32_st;
        t = ((old >> 18) ^ old) >> 27;
        p32_st = old * PCG32_MUL + p32_inc;
        return rotl32(t[31:0], 32 - int'(old >> 59));
      end
      GEN_P64: begin
        o128 = p64_st;
        p64_st = pcg64_adv(o128);
        r = rotl64(o128[127:64] ^ o128[63:0], 64 - int'(o128[127:122]));
        return r[63:32];
      end
      default: return 32'd0;
    endcase
  endfunction

  // 53-bit fraction times the pool, rounded to 53 significant bits (ties to even), floored
  function automatic int unsigned frac_class(bit [31:0] w1, bit [31:0] w2);
    bit [63:0] n, p, q, half, rem;
    int unsigned s;
    n = ({32'd0, w1 >> 5} << 26) + {32'd0, w2 >> 6};
    p = n * POOL;
    s = 0;
    while ((p >> s) >= (64'd1 << 53)) s++;
    if (s > 0) begin
      half = 64'd1 << (s - 1);
      rem = p & ((64'd1 << s) - 1);
      q = p >> s;
      if (rem > half || (rem == half && q[0])) q++;
      p = q << s;
    end
    q = p >> 53;
    return (q >= POOL) ? POOL - 1 : int'(q);
  endfunction

  function automatic out_item_t draw_mask(in_item_t it);
    bit [127:0] mask;
    bit [63:0] prod;
    bit [63:0] thr;
    bit [31:0] w;
    int unsigned taken, rounds, cls;
    bit ok, skip;
    out_item_t res;
    mask = '0;
    thr = 64'h1_0000_0000 % POOL;
    taken = 0;
    rounds = 0;
    ok = 1'b1;
    seed_gens(it.seed);
    while (taken < DRAWS) begin
      rounds++;
      if (rounds > ROUND_CAP) begin
        ok = 1'b0;
        break;
      end
      w = gen_word(it.generator);
      skip = 1'b0;
      prod = {32'd0, w} * POOL;
      case (it.sampler)
        SMP_TRUNC: cls = int'(prod >> 32);
        SMP_MOD: cls = w % POOL;
        SMP_UMOD: begin
          skip = ({32'd0, w} >= 64'h1_0000_0000 - thr);
          cls = w % POOL;
        end
        SMP_LEM: begin
          skip = ({32'd0, prod[31:0]} < thr);
          cls = int'(prod >> 32);
        end
        SMP_D53: cls = frac_class(w, gen_word(it.generator));
        default: begin
          cls = w & 32'd127;
          skip = (cls >= POOL);
        end
      endcase
      if (!skip && !mask[cls]) begin
        mask[cls] = 1'b1;
        taken++;
      end
    end
    res.mask_low = ok ? mask[63:0] : 64'd0;
    res.mask_high = ok ? mask[79:64] : 16'd0;
    res.complete = ok;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout, nothing moving");
        $display("[FAIL] regression broken");
        $finish;
      end
      if (in_valid && in_ready)
        exp_masks.push_back(cur_known ? cur_res : draw_mask(in_item));
      if (out_valid && out_ready) begin
        if (exp_masks.size() == 0) begin
          report_mismatch("unexpected item", {48'd0, out_item.mask_high}, 64'd0);
        end else begin
          out_item_t e;
          e = exp_masks.pop_front();
          if (out_item.mask_low !== e.mask_low)
            report_mismatch("mask_low", out_item.mask_low, e.mask_low);
          if (out_item.mask_high !== e.mask_high)
            report_mismatch("mask_high", {48'd0, out_item.mask_high}, {48'd0, e.mask_high});
          if (out_item.complete !== e.complete)
            report_mismatch("complete", {63'd0, out_item.complete}, {63'd0, e.complete});
        end
      end
    end
  end

  // receiver: stall mode is redrawn at random from four modes
  int unsigned rx_cyc = 0;
  int unsigned rx_mode = 0;
  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= (rx_cyc % 3 == 0);
      2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(in_item_t it, logic known, out_item_t res, inout int unsigned burst);
    int unsigned gap;
    if (burst == 0) begin
      burst = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    cur_known = known;
    cur_res = res;
    // in_ready only moves at rising edges, so its value here holds at the next edge
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    int unsigned burst;
    int unsigned roll;
    burst = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    foreach (DIR_VECS[i]) begin
      it.seed = DIR_VECS[i].seed;
      it.generator = DIR_VECS[i].gen;
      it.sampler = DIR_VECS[i].smp;
      send_item(it, DIR_VECS[i].known, DIR_VECS[i].res, burst);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      roll = $urandom_range(0, 99);
      it.seed = (roll < 3) ? 32'd0 : (roll < 6) ? 32'hFFFF_FFFF : $urandom;
      // dead generators are slow and only ever fail, keep them rare
      it.generator = ($urandom_range(0, 99) < 3) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
      it.sampler = 3'($urandom_range(0, 7));
      send_item(it, 1'b0, FAILED, burst);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_masks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
